// ----- rtl/core/wsm_pkg.sv -----
// ----------------------------------------------------------------------------
// wsm_pkg: shared types and constants of the wildcard star matcher
// Pattern geometry, register map codes, config bundle and the case fold.
// ----------------------------------------------------------------------------
package wsm_pkg;

   localparam int PATTERN_MAX = 32;               // pattern positions, 4..32
   localparam int VEC_W       = PATTERN_MAX + 1;  // active position vector
   localparam int LEN_W       = 6;
   localparam int CHAR_W      = 8;
   localparam int CHAR_WORDS  = 4;
   localparam int CSR_DATA_W  = 64;
   localparam int CHARS_W     = CHAR_WORDS * CSR_DATA_W;
   localparam int CSR_ADDR_W  = 6;
   localparam int REG_IDX_W   = 3;

   localparam logic [CHAR_W-1:0] STAR_CHAR    = 8'h2A;
   localparam logic [CHAR_W-1:0] UPPER_A      = 8'h41;
   localparam logic [CHAR_W-1:0] UPPER_Z      = 8'h5A;
   localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'h20;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_PATTERN_LEN = 3'd0,
      REG_CHARS_0     = 3'd1,
      REG_CHARS_1     = 3'd2,
      REG_CHARS_2     = 3'd3,
      REG_CHARS_3     = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [LEN_W-1:0]   len;
      logic [CHARS_W-1:0] chars;
   } cfg_type;

   // ASCII letter folding: upper case maps onto lower case
   function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] r;
      r = c;
      if (c >= UPPER_A && c <= UPPER_Z) begin
         r = c + CASE_OFFSET;
      end
      return r;
   endfunction

endpackage

// ----- rtl/core/wsm_csr.sv -----
// ----------------------------------------------------------------------------
// wsm_csr: configuration registers
// APB-style register file holding pattern length and pattern characters.
// ----------------------------------------------------------------------------
module wsm_csr
   import wsm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg_o
);

   logic [LEN_W-1:0]      len_ff;
   logic [CSR_DATA_W-1:0] chars_ff [CHAR_WORDS];
   logic                  wr_en;
   reg_index_type         reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = reg_index_type'(paddr[CSR_ADDR_W-1:CSR_ADDR_W-REG_IDX_W]);

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         for (int w = 0; w < CHAR_WORDS; w++) begin
            chars_ff[w] <= '0;
         end
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_PATTERN_LEN: len_ff      <= pwdata[LEN_W-1:0];
            REG_CHARS_0:     chars_ff[0] <= pwdata;
            REG_CHARS_1:     chars_ff[1] <= pwdata;
            REG_CHARS_2:     chars_ff[2] <= pwdata;
            REG_CHARS_3:     chars_ff[3] <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_PATTERN_LEN: prdata = {{(CSR_DATA_W-LEN_W){1'b0}}, len_ff};
         REG_CHARS_0:     prdata = chars_ff[0];
         REG_CHARS_1:     prdata = chars_ff[1];
         REG_CHARS_2:     prdata = chars_ff[2];
         REG_CHARS_3:     prdata = chars_ff[3];
         default:         prdata = '0;
      endcase
   end

   assign cfg_o.len   = len_ff;
   assign cfg_o.chars = {chars_ff[3], chars_ff[2], chars_ff[1], chars_ff[0]};

endmodule

// ----- rtl/core/wsm_cell.sv -----
// ----------------------------------------------------------------------------
// wsm_cell: one pattern position
// Holds the active bit of its position and matches one pattern character.
// ----------------------------------------------------------------------------
module wsm_cell
   import wsm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [CHAR_W-1:0] pat_char_i,   // pattern char in front of this position
   input  logic [CHAR_W-1:0] value_char_i,
   input  logic              enable_i,     // position lies within pattern length
   input  logic              src_prev_i,   // neighbor's bit before the step
   input  logic              src_self_i,   // own bit before the step
   input  logic              load_i,
   input  logic              next_i,
   output logic              gen_o,        // set by the character itself
   output logic              prop_o,       // star: carries the neighbor forward
   output logic              act_o
);

   logic is_star;
   logic char_eq;
   logic act_ff;
   logic act_in;

   assign is_star = (pat_char_i == STAR_CHAR);
   assign char_eq = (fold_char(pat_char_i) == fold_char(value_char_i));

   assign gen_o  = enable_i & (is_star ? src_self_i : (src_prev_i & char_eq));
   assign prop_o = enable_i & is_star;

   assign act_in = load_i ? next_i : act_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b0;
      end else begin
         act_ff <= act_in;
      end
   end

   assign act_o = act_ff;

endmodule

// ----- rtl/core/wsm_closure.sv -----
// ----------------------------------------------------------------------------
// wsm_closure: star closure across the position row
// Prefix scan of generate/propagate pairs, log depth over the row.
// ----------------------------------------------------------------------------
module wsm_closure
   import wsm_pkg::*;
(
   input  logic [VEC_W-1:0] gen_i,
   input  logic [VEC_W-1:0] prop_i,
   output logic [VEC_W-1:0] vec_o
);

   localparam int SCAN_LEVELS = $clog2(VEC_W);

   always_comb begin
      logic [VEC_W-1:0] g;
      logic [VEC_W-1:0] p;
      logic [VEC_W-1:0] gn;
      logic [VEC_W-1:0] pn;
      g = gen_i;
      p = prop_i;
      for (int lvl = 0; lvl < SCAN_LEVELS; lvl++) begin
         gn = g;
         pn = p;
         for (int i = (1 << lvl); i < VEC_W; i++) begin
            gn[i] = g[i] | (p[i] & g[i - (1 << lvl)]);
            pn[i] = p[i] & p[i - (1 << lvl)];
         end
         g = gn;
         p = pn;
      end
      vec_o = g;
   end

endmodule

// ----- rtl/core/wildcard_star_matcher_core.sv -----
// ----------------------------------------------------------------------------
// wildcard_star_matcher_core: streamed glob match with '*' wildcard
// Case-insensitive whole-string match of a character stream against the
// configured pattern, using a row of position cells.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------------
//  req     | in        | req_valid/req_stall | value_char, first/last, empty
//  rsp     | out       | rsp_valid/rsp_stall | matched
//  csr     | in/out    | psel/penable/pready | 64-bit registers at 8*index
//
//  One character per cycle while req_stall is low; a result appears in the cycle
//  after the transaction that ends a value and sits in the output register until taken.
//  All positions of the cell row step together.
//  Synchronous active-high reset clears the active positions, the config registers and rsp_valid.
//  req_stall rises only for a value-ending transaction while an earlier
//  result is still stalled in the output register.
// ----------------------------------------------------------------------------
module wildcard_star_matcher_core
   import wsm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // input transaction
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [CHAR_W-1:0]     req_value_char,
   input  logic                  req_first_char,
   input  logic                  req_last_char,
   input  logic                  req_empty_value,
   // result transaction
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_matched,
   // configuration
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type          cfg;
   logic [LEN_W-1:0] eff_len;

   logic [VEC_W-1:0] act;          // current active positions
   logic [VEC_W-1:0] enable;       // position within pattern
   logic [VEC_W-1:0] prop;         // star in front of position
   logic [VEC_W-1:0] start_gen;
   logic [VEC_W-1:0] start_vec;    // restart vector: position 0 plus star run
   logic [VEC_W-1:0] src;          // vector the character steps from
   logic [VEC_W-1:0] step_gen;
   logic [VEC_W-1:0] step_vec;     // vector after the character
   logic [VEC_W-1:0] next_vec;

   logic req_accept;
   logic gives_result;
   logic restart;
   logic match_bit;

   logic act0_ff;
   logic act0_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic rsp_matched_ff;
   logic rsp_matched_in;

   // ---------------------------------------------------------------- config
   wsm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg_o   (cfg)
   );

   // lengths above the row size clip to the row size
   assign eff_len = (cfg.len > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : cfg.len;

   // -------------------------------------------------------------- handshake
   assign gives_result = req_last_char | req_empty_value;
   // non-ending transactions pass even while a result waits downstream
   assign req_stall    = rsp_valid_ff & rsp_stall & gives_result;
   assign req_accept   = req_valid & ~req_stall;
   assign restart      = req_first_char | req_empty_value;

   // ------------------------------------------------------------ cell row
   assign enable[0]    = 1'b0;
   assign prop[0]      = 1'b0;
   assign step_gen[0]  = 1'b0;      // no character ever lands on position 0
   assign act[0]       = act0_ff;
   assign start_gen    = {{(VEC_W-1){1'b0}}, 1'b1};

   assign src      = restart ? start_vec : act;
   assign next_vec = req_empty_value ? start_vec : step_vec;

   for (genvar k = 1; k < VEC_W; k++) begin : g_cell
      assign enable[k] = (LEN_W'(k) <= eff_len);

      wsm_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .pat_char_i   (cfg.chars[(k-1)*CHAR_W +: CHAR_W]),
         .value_char_i (req_value_char),
         .enable_i     (enable[k]),
         .src_prev_i   (src[k-1]),
         .src_self_i   (src[k]),
         .load_i       (req_accept),
         .next_i       (next_vec[k]),
         .gen_o        (step_gen[k]),
         .prop_o       (prop[k]),
         .act_o        (act[k])
      );
   end

   // restart closure depends on the pattern alone
   wsm_closure u_start_closure (
      .gen_i  (start_gen),
      .prop_i (prop),
      .vec_o  (start_vec)
   );

   // stars carry freshly reached positions forward in the same step
   wsm_closure u_step_closure (
      .gen_i  (step_gen),
      .prop_i (prop),
      .vec_o  (step_vec)
   );

   // position 0 is only ever set by an empty value's restart
   assign act0_in = req_accept ? next_vec[0] : act0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         act0_ff <= 1'b0;
      end else begin
         act0_ff <= act0_in;
      end
   end

   // ---------------------------------------------------------- result stage
   assign match_bit = next_vec[eff_len];

   always_comb begin
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      rsp_matched_in = rsp_matched_ff;
      if (req_accept & gives_result) begin
         rsp_valid_in   = 1'b1;
         rsp_matched_in = match_bit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_matched_ff <= rsp_matched_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_matched = rsp_matched_ff;

endmodule

// ----- rtl/core/wsm_checker.sv -----
// ----------------------------------------------------------------------------
// wsm_checker: port-level checks of the matcher
// Watches the transaction handshakes; bound onto the top level.
// ----------------------------------------------------------------------------
module wsm_checker
   import wsm_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic req_last_char,
   input logic req_empty_value,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_matched
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_matched))
      else $error("stalled result changed");

   // a value-ending transaction yields a result in the next cycle
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_last_char || req_empty_value) |=> rsp_valid)
      else $error("missing result after value end");

   // a mid-value transaction creates no result
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !req_last_char && !req_empty_value && !rsp_valid
      |=> !rsp_valid)
      else $error("result without value end");

   // input stalls only behind a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output back-pressure");

endmodule

bind wildcard_star_matcher_core wsm_checker u_wsm_checker (.*);

// ----- tb/wsm_match_checker.sv -----
// ----------------------------------------------------------------------------
// wsm_match_checker: result predictor and scoreboard for the star matcher
// Watches the register port and both channels, keeps its own copy of the
// pattern and of the active position vector, and checks every result.
// ----------------------------------------------------------------------------
module wsm_match_checker
   import wsm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [CHAR_W-1:0]     req_value_char,
   input  logic                  req_first_char,
   input  logic                  req_last_char,
   input  logic                  req_empty_value,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic                  rsp_matched,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   input  logic [CSR_DATA_W-1:0] prdata,
   input  logic                  pready,
   output int unsigned           fail_count,
   output int unsigned           outstanding
);

   logic [LEN_W-1:0]      len_copy;
   logic [CSR_DATA_W-1:0] chars_copy [CHAR_WORDS];
   logic [VEC_W-1:0]      live_pos;
   logic                  expected_matches [$];

   function automatic int used_len();
      return (int'(len_copy) > PATTERN_MAX) ? PATTERN_MAX : int'(len_copy);
   endfunction

   function automatic logic [CHAR_W-1:0] pat_at(input int k);
      return chars_copy[k / 8][(k % 8) * CHAR_W +: CHAR_W];
   endfunction

   function automatic logic [CHAR_W-1:0] lower(input logic [CHAR_W-1:0] c);
      return (c >= 8'h41 && c <= 8'h5A) ? (c | 8'h20) : c;
   endfunction

   // carry each live position across the stars that follow it
   function automatic logic [VEC_W-1:0] star_carry(input logic [VEC_W-1:0] v);
      for (int k = 1; k <= used_len(); k++) begin
         if (pat_at(k - 1) == STAR_CHAR && v[k - 1]) begin
            v[k] = 1'b1;
         end
      end
      return v;
   endfunction

   function automatic logic [VEC_W-1:0] consume(input logic [VEC_W-1:0] v,
                                                input logic [CHAR_W-1:0] c);
      logic [VEC_W-1:0]  nv;
      logic [CHAR_W-1:0] p;
      nv = '0;
      for (int k = 1; k <= used_len(); k++) begin
         p = pat_at(k - 1);
         if (p == STAR_CHAR) begin
            nv[k] = v[k];
         end else begin
            nv[k] = v[k - 1] && (lower(p) == lower(c));
         end
      end
      return star_carry(nv);
   endfunction

   always @(posedge clock) begin
      reg_index_type         idx;
      logic [CSR_DATA_W-1:0] rd_expect;
      logic                  want;
      if (reset) begin
         fail_count = 0;
         len_copy = '0;
         foreach (chars_copy[i]) chars_copy[i] = '0;
         live_pos = '0;
         expected_matches.delete();
      end else begin
         // register access
         if (psel && penable && pready) begin
            idx = reg_index_type'(paddr[CSR_ADDR_W-1:3]);
            if (idx == REG_PATTERN_LEN) begin
               rd_expect = CSR_DATA_W'(len_copy);
            end else begin
               rd_expect = chars_copy[int'(idx) - int'(REG_CHARS_0)];
            end
            if (pwrite) begin
               if (idx == REG_PATTERN_LEN) begin
                  len_copy = pwdata[LEN_W-1:0];
               end else begin
                  chars_copy[int'(idx) - int'(REG_CHARS_0)] = pwdata;
               end
            end else if (prdata !== rd_expect) begin
               $error("prdata: expected %h, actual %h", rd_expect, prdata);
               fail_count++;
            end
         end
         // results before requests: a request never answers in its own cycle
         if (rsp_valid && !rsp_stall) begin
            if (expected_matches.size() == 0) begin
               $error("matched: expected none, actual %0b", rsp_matched);
               fail_count++;
            end else begin
               want = expected_matches.pop_front();
               if (rsp_matched !== want) begin
                  $error("matched: expected %0b, actual %0b", want, rsp_matched);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (req_empty_value || req_first_char) begin
               live_pos = star_carry(VEC_W'(1));
            end
            if (!req_empty_value) begin
               live_pos = consume(live_pos, req_value_char);
            end
            if (req_empty_value || req_last_char) begin
               expected_matches.push_back(live_pos[used_len()]);
            end
         end
      end
      outstanding <= expected_matches.size();
   end

endmodule

// ----- tb/tb_wildcard_star_matcher_core.sv -----
// ----------------------------------------------------------------------------
// tb_wildcard_star_matcher_core: stimulus and verdict for the star matcher
// Loads a series of patterns through the register port and streams values
// against each: a short directed run first, then random values built from
// the pattern, framing noise and empty values, with random idling on both
// channels. Checking lives in wsm_match_checker.
// ----------------------------------------------------------------------------
module tb_wildcard_star_matcher_core;
   import wsm_pkg::*;

   typedef logic [CHAR_W-1:0] char_type;

   // limit of the watchdog that ends a run with no progress on any port
   localparam int IDLE_LIMIT  = 2000;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 150;

   logic                  clock;
   logic                  reset           = 1'b1;
   logic                  req_valid       = 1'b0;
   logic                  req_stall;
   logic [CHAR_W-1:0]     req_value_char  = '0;
   logic                  req_first_char  = 1'b0;
   logic                  req_last_char   = 1'b0;
   logic                  req_empty_value = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall       = 1'b0;
   logic                  rsp_matched;
   logic                  psel            = 1'b0;
   logic                  penable         = 1'b0;
   logic                  pwrite          = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr           = '0;
   logic [CSR_DATA_W-1:0] pwdata          = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;
   int unsigned           fail_count;
   int unsigned           outstanding;

   // pattern currently loaded, kept here to build matching values
   char_type          pat [32];
   logic [LEN_W-1:0]  pat_len;

   logic req_calm = 1'b0;   // sender never idles
   logic rsp_calm = 1'b0;   // receiver never stalls
   int   stall_left  = 0;
   int   idle_cycles = 0;
   int   sent_items  = 0;

   wildcard_star_matcher_core u_dut (.*);
   wsm_match_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // mostly short gaps, some medium, a few long ones
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 10);
      return $urandom_range(15, 40);
   endfunction

   // receiver back-pressure, independent of rsp_valid
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (!rsp_calm && $urandom_range(0, 9) < 3) begin
         rsp_stall  <= 1'b1;
         stall_left <= idle_len() - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // watchdog: any transaction or register access counts as progress
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (psel && penable && pready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // one transaction; valid stays high afterwards so back-to-back items
   // need no extra edge
   task automatic send_item(input char_type c, input bit first, input bit last,
                            input bit empty);
      int g;
      g = (req_calm || $urandom_range(0, 1) == 1) ? 0 : idle_len();
      if (g != 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_value_char  <= c;
      req_first_char  <= first;
      req_last_char   <= last;
      req_empty_value <= empty;
      do @(posedge clock); while (req_stall);
      sent_items++;
   endtask

   // a whole value with its first and last marks; no characters means an
   // empty-value transaction with random framing bits
   task automatic send_value(input char_type v[$]);
      if (v.size() == 0) begin
         send_item(char_type'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), 1'b1);
      end else begin
         foreach (v[i]) send_item(v[i], i == 0, i == v.size() - 1, 1'b0);
      end
   endtask

   // stop sending and wait until every predicted result has been taken
   task automatic wait_drained(input int extra);
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   // setup cycle, then access cycle until pready
   task automatic csr_access(input bit wr, input reg_index_type idx,
                             input logic [CSR_DATA_W-1:0] d);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= CSR_ADDR_W'({idx, 3'b000});
      pwdata  <= d;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // write every register from pat/pat_len, then read one back
   task automatic load_pattern();
      logic [CSR_DATA_W-1:0] w;
      // junk above the length field must be dropped by the block
      w = {$urandom, $urandom};
      w[LEN_W-1:0] = pat_len;
      csr_access(1'b1, REG_PATTERN_LEN, w);
      for (int i = 0; i < CHAR_WORDS; i++) begin
         for (int b = 0; b < 8; b++) w[b * CHAR_W +: CHAR_W] = pat[i * 8 + b];
         csr_access(1'b1, reg_index_type'(int'(REG_CHARS_0) + i), w);
      end
      csr_access(1'b0, reg_index_type'($urandom_range(int'(REG_PATTERN_LEN),
                                                      int'(REG_CHARS_3))), '0);
   endtask

   // value that follows the pattern: stars expand to 0..3 characters,
   // letters flip case at random; a quarter of the values get one random edit
   task automatic make_value(output char_type v[$]);
      int       n;
      char_type c;
      v = {};
      n = (int'(pat_len) > PATTERN_MAX) ? PATTERN_MAX : int'(pat_len);
      for (int k = 0; k < n; k++) begin
         c = pat[k];
         if (c == STAR_CHAR) begin
            repeat ($urandom_range(0, 3)) begin
               v.push_back($urandom_range(0, 1) ?
                           char_type'(8'h61 + $urandom_range(0, 2)) :
                           char_type'($urandom_range(0, 255)));
            end
         end else begin
            if (((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) &&
                $urandom_range(0, 1) == 1) begin
               c = c ^ 8'h20;
            end
            v.push_back(c);
         end
      end
      if ($urandom_range(0, 3) == 0) begin
         c = $urandom_range(0, 1) ? char_type'(8'h61 + $urandom_range(0, 2))
                                  : char_type'($urandom_range(0, 255));
         case ($urandom_range(0, 3))
            0: if (v.size() != 0) v[$urandom_range(0, v.size() - 1)] = c;
            1: if (v.size() != 0) v.delete($urandom_range(0, v.size() - 1));
            2: v.insert($urandom_range(0, v.size()), c);
            default: v.push_back(c);
         endcase
      end
   endtask

   initial begin
      char_type v[$];
      int       r;
      int       stop_at;
      bit       open_value;
      open_value = 1'b0;
      pat        = '{default: 8'h00};
      pat_len    = '0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // ---- directed: registers still at reset, empty pattern ----
      send_item(8'h00, 1'b0, 1'b1, 1'b0);   // no first mark after reset: no match
      send_item(8'hFF, 1'b0, 1'b0, 1'b1);   // empty value with no marks: matches
      send_item(8'h61, 1'b1, 1'b1, 1'b0);   // one character vs empty pattern

      // pattern "a*Z\xFF": case folding, empty star run, top byte
      wait_drained(4);
      pat[0]  = 8'h61;
      pat[1]  = STAR_CHAR;
      pat[2]  = 8'h5A;
      pat[3]  = 8'hFF;
      pat_len = 6'd4;
      load_pattern();
      v = '{8'h41, 8'h7A, 8'hFF};
      send_value(v);
      v = '{8'h61, 8'h51, 8'h7A, 8'hFF};
      send_value(v);
      v = '{8'h61, 8'h7A, 8'h00};
      send_value(v);
      send_item(8'h00, 1'b1, 1'b0, 1'b1);   // empty value, first mark only
      send_item(8'hFF, 1'b0, 1'b0, 1'b1);   // empty value ignores its char
      send_item(8'h41, 1'b1, 1'b0, 1'b0);   // left open across the next load

      // all stars with a length past the maximum; the open value continues
      // under the new pattern without a restart
      wait_drained(4);
      pat     = '{default: STAR_CHAR};
      pat_len = 6'd63;
      load_pattern();
      send_item(8'h80, 1'b0, 1'b1, 1'b0);
      send_item(8'h00, 1'b1, 1'b1, 1'b1);
      v = '{8'h78, 8'h59};
      send_value(v);

      // '@' and '[' sit next to the letters and must not fold
      wait_drained(4);
      pat[0]  = 8'h40;
      pat[1]  = 8'h5B;
      pat_len = 6'd2;
      load_pattern();
      v = '{8'h60, 8'h7B};
      send_value(v);
      v = '{8'h40, 8'h5B};
      send_value(v);
      send_item(8'h40, 1'b0, 1'b1, 1'b0);   // continues an ended value

      // ---- random phases, one pattern each ----
      for (int ph = 0; ph < PHASES; ph++) begin
         wait_drained(4);
         for (int k = 0; k < 32; k++) begin
            r = $urandom_range(0, 9);
            if (r < 3) begin
               pat[k] = STAR_CHAR;
            end else if (r < 8) begin
               pat[k] = char_type'(8'h61 + $urandom_range(0, 2)) ^
                        ($urandom_range(0, 1) ? 8'h20 : 8'h00);
            end else begin
               pat[k] = char_type'($urandom_range(0, 255));
            end
         end
         case (ph)
            0: pat_len = 6'd32;
            1: pat_len = 6'd0;
            2: pat_len = 6'(33 + $urandom_range(0, 30));
            3: begin
               pat     = '{default: 8'hFF};
               pat_len = 6'($urandom_range(1, 4));
            end
            default: begin
               r = $urandom_range(0, 9);
               pat_len = (r < 7) ? 6'($urandom_range(1, 10)) :
                         (r < 9) ? 6'($urandom_range(11, 32)) :
                                   6'($urandom_range(33, 63));
            end
         endcase
         load_pattern();
         req_calm <= ($urandom_range(0, 3) == 0);
         rsp_calm <= ($urandom_range(0, 3) == 0);

         // finish the value left open before the load, under the new pattern
         if (open_value) begin
            send_item(char_type'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0);
         end

         stop_at = sent_items + PHASE_ITEMS;
         while (sent_items < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 80) begin
               make_value(v);
               send_value(v);
            end else if (r < 92) begin
               // framing noise: any mix of marks
               send_item(char_type'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else if (r < 97) begin
               send_item(char_type'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), 1'b1);
            end else begin
               // hold off until the block has handed back everything
               wait_drained(0);
            end
         end

         open_value = ($urandom_range(0, 2) == 0);
         if (open_value) begin
            send_item(char_type'($urandom_range(0, 255)), 1'b1, 1'b0, 1'b0);
         end
      end

      wait_drained(8);
      if (fail_count == 0 && outstanding == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/wsm_pkg.sv
rtl/core/wsm_csr.sv
rtl/core/wsm_cell.sv
rtl/core/wsm_closure.sv
rtl/core/wildcard_star_matcher_core.sv
rtl/core/wsm_checker.sv
tb/wsm_match_checker.sv
tb/tb_wildcard_star_matcher_core.sv
